// ===== sv/tile_map_background_pixel_fetch_assert.svh =====
// Assertion macros shared by the tile map background pixel fetch modules.
`ifndef TILE_MAP_BACKGROUND_PIXEL_FETCH_ASSERT_SVH
`define TILE_MAP_BACKGROUND_PIXEL_FETCH_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define TMBPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// A condition in one cycle implies another condition in the next cycle.
`define TMBPF_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// ===== sv/tmbpf_pkg.sv =====
// Shared types, codes and helpers of the tile map background pixel fetch block.
`default_nettype none

package tmbpf_pkg;

    localparam int VRAM_HALFWORDS_DEF  = 49152;
    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int QUEUE_DEPTH         = 4;

    localparam int BYTE_ADDR_W = 17;
    localparam int HW_ADDR_W   = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int S_DATA_W    = 56;
    localparam int S_USER_W    = 2;
    localparam int M_DATA_W    = 16;
    localparam int M_USER_W    = 1;

    // Request types carried in s_tuser.
    localparam logic [1:0] REQ_VRAM_WR = 2'd0;
    localparam logic [1:0] REQ_PAL_WR  = 2'd1;
    localparam logic [1:0] REQ_PIXEL   = 2'd2;

    // Video modes.
    localparam logic [1:0] MODE_TEXT     = 2'd0;
    localparam logic [1:0] MODE_AFFINE_1 = 2'd1;
    localparam logic [1:0] MODE_AFFINE_2 = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_VIDEO_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_SIZE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TILE_BLOCK = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_BLOCK  = 2'd3;

    typedef struct packed {
        logic [1:0] video_mode;
        logic [1:0] map_size;
        logic [1:0] tile_block;
        logic [4:0] map_block;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_VRAM_WR,
        CMD_PAL_WR,
        CMD_PIXEL
    } cmd_t;

    // One classified item as it waits between front and back.
    typedef struct packed {
        cmd_t                 kind;
        logic                 in_map;
        logic                 affine;
        logic [HW_ADDR_W-1:0] map_hw;
        logic                 byte_hi;
        logic [2:0]           fine_x;
        logic [2:0]           fine_y;
        logic [15:0]          wr_addr;
        logic [15:0]          wr_data;
    } qentry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MAP,
        BK_TILE,
        BK_PAL
    } back_state_t;

    // Byte address to halfword index, wrapped once around the RAM size.
    // Every address the block forms stays below twice the smallest RAM size.
    function automatic logic [HW_ADDR_W-1:0] wrap_hw(
        input logic [BYTE_ADDR_W-1:0] byte_addr,
        input logic [BYTE_ADDR_W-1:0] limit
    );
        logic [BYTE_ADDR_W-1:0] hw;
        hw = {1'b0, byte_addr[BYTE_ADDR_W-1:1]};
        if (hw >= limit) begin
            hw = hw - limit;
        end
        return hw[HW_ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/tile_map_background_pixel_fetch.sv =====
// Top level of the tile map background pixel fetch block.
`default_nettype none

// Holds a video RAM of halfwords and a palette, both filled by write items,
// and answers each pixel request with one palette color and an inside flag.
// Text mode reads a 16-bit map entry and a 4 bpp tile nibble; affine modes
// read a byte map and an 8 bpp tile byte. In the back end a pixel request's
// map read, tile read and palette read follow one another through the single
// registered read port of each RAM, and the BK_PAL state then loads the
// output register once it is free. A video RAM or palette write is done as
// it is popped; out-of-range writes and unused request types are dropped at
// the front and never reach the back end. A four-entry queue separates intake
// from the back end, and the output register lets the next item start while a
// result waits on m_tready. Memory contents are undefined until written.
module tile_map_background_pixel_fetch #(
    parameter int VRAM_HALFWORDS  = tmbpf_pkg::VRAM_HALFWORDS_DEF,
    parameter int PALETTE_ENTRIES = tmbpf_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [tmbpf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tmbpf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // mem_address[15:0], write_data[31:16], pixel_x[41:32], pixel_y[51:42], zero pad
    input  wire logic [tmbpf_pkg::S_DATA_W-1:0]    s_tdata,
    // req_type[1:0]
    input  wire logic [tmbpf_pkg::S_USER_W-1:0]    s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // pixel_color[15:0]
    output logic [tmbpf_pkg::M_DATA_W-1:0]         m_tdata,
    // inside_res[0]
    output logic [tmbpf_pkg::M_USER_W-1:0]         m_tuser
);

    logic               q_full;
    logic               push;
    tmbpf_pkg::qentry_t push_entry;
    logic               pop;
    logic               head_valid;
    tmbpf_pkg::qentry_t head;
    logic [1:0]         tile_block;

    tmbpf_front #(
        .VRAM_HALFWORDS (VRAM_HALFWORDS),
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_entry(push_entry),
        .tile_block(tile_block)
    );

    tmbpf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head      (head)
    );

    tmbpf_back #(
        .VRAM_HALFWORDS (VRAM_HALFWORDS),
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tile_block(tile_block),
        .head_valid(head_valid),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== sv/tmbpf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tmbpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/tmbpf_front.sv =====
// Front end: configuration registers, item intake, classification and map address.
`default_nettype none

module tmbpf_front #(
    parameter int VRAM_HALFWORDS  = tmbpf_pkg::VRAM_HALFWORDS_DEF,
    parameter int PALETTE_ENTRIES = tmbpf_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [tmbpf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tmbpf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [tmbpf_pkg::S_DATA_W-1:0]      s_tdata,
    input  wire logic [tmbpf_pkg::S_USER_W-1:0]      s_tuser,
    input  wire logic                                q_full,
    output logic                                     push,
    output tmbpf_pkg::qentry_t                       push_entry,
    output logic [1:0]                               tile_block
);

    localparam int BW = tmbpf_pkg::BYTE_ADDR_W;
    localparam logic [BW-1:0] VRAM_LIMIT = BW'(VRAM_HALFWORDS);
    localparam logic [BW-1:0] PAL_LIMIT  = BW'(PALETTE_ENTRIES);

    tmbpf_pkg::cfg_t cfg_reg;
    tmbpf_pkg::cfg_t cfg_next;

    logic [15:0] mem_address;
    logic [15:0] write_data;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic        accept;
    logic        keep;

    logic [1:0]    screen;
    logic [5:0]    text_upper;
    logic [BW-1:0] text_byte;
    logic          text_inside;
    logic [10:0]   side;
    logic [2:0]    aff_shift;
    logic [BW-1:0] aff_byte;
    logic          aff_inside;
    logic [BW-1:0] map_byte;
    logic          in_map;
    logic          affine;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                tmbpf_pkg::CFG_VIDEO_MODE: cfg_next.video_mode = cfg_wdata[1:0];
                tmbpf_pkg::CFG_MAP_SIZE:   cfg_next.map_size   = cfg_wdata[1:0];
                tmbpf_pkg::CFG_TILE_BLOCK: cfg_next.tile_block = cfg_wdata[1:0];
                tmbpf_pkg::CFG_MAP_BLOCK:  cfg_next.map_block  = cfg_wdata[4:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign tile_block = cfg_reg.tile_block;

    assign mem_address = s_tdata[15:0];
    assign write_data  = s_tdata[31:16];
    assign pixel_x     = s_tdata[41:32];
    assign pixel_y     = s_tdata[51:42];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    // Text mode: screens of 256 pixels, one 2 KiB map block each.
    always_comb begin
        screen      = cfg_reg.map_size[0] ? {pixel_y[8], pixel_x[8]} : {1'b0, pixel_y[8]};
        text_upper  = 6'(cfg_reg.map_block) + 6'(screen);
        text_byte   = {text_upper, pixel_y[7:3], pixel_x[7:3], 1'b0};
        text_inside = (cfg_reg.map_size[0] ? !pixel_x[9] : (pixel_x[9:8] == 2'b00)) &&
                      (cfg_reg.map_size[1] ? !pixel_y[9] : (pixel_y[9:8] == 2'b00));
    end

    // Affine mode: square byte map, one byte per 8x8 tile.
    always_comb begin
        side       = 11'd128 << cfg_reg.map_size;
        aff_shift  = 3'd4 + {1'b0, cfg_reg.map_size};
        aff_inside = ({1'b0, pixel_x} < side) && ({1'b0, pixel_y} < side);
        aff_byte   = BW'({cfg_reg.map_block, 11'b0}) + (BW'(pixel_y[9:3]) << aff_shift) +
                     BW'(pixel_x[9:3]);
    end

    always_comb begin
        unique case (cfg_reg.video_mode) inside
            tmbpf_pkg::MODE_TEXT: begin
                map_byte = text_byte;
                in_map   = text_inside;
                affine   = 1'b0;
            end
            tmbpf_pkg::MODE_AFFINE_1, tmbpf_pkg::MODE_AFFINE_2: begin
                map_byte = aff_byte;
                in_map   = aff_inside;
                affine   = 1'b1;
            end
            default: begin
                map_byte = text_byte;
                in_map   = 1'b0;
                affine   = 1'b0;
            end
        endcase
    end

    // Out-of-range writes and the unused request type are dropped here.
    always_comb begin
        push_entry.kind    = tmbpf_pkg::CMD_PIXEL;
        push_entry.in_map  = in_map;
        push_entry.affine  = affine;
        push_entry.map_hw  = tmbpf_pkg::wrap_hw(map_byte, VRAM_LIMIT);
        push_entry.byte_hi = map_byte[0];
        push_entry.fine_x  = pixel_x[2:0];
        push_entry.fine_y  = pixel_y[2:0];
        push_entry.wr_addr = mem_address;
        push_entry.wr_data = write_data;
        unique case (s_tuser)
            tmbpf_pkg::REQ_VRAM_WR: begin
                push_entry.kind = tmbpf_pkg::CMD_VRAM_WR;
                keep            = {1'b0, mem_address} < VRAM_LIMIT;
            end
            tmbpf_pkg::REQ_PAL_WR: begin
                push_entry.kind = tmbpf_pkg::CMD_PAL_WR;
                keep            = {1'b0, mem_address} < PAL_LIMIT;
            end
            tmbpf_pkg::REQ_PIXEL: begin
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = accept && keep;

endmodule

`default_nettype wire

// ===== sv/tmbpf_queue.sv =====
// Short queue of classified items between the front and the back.
`default_nettype none
`include "tile_map_background_pixel_fetch_assert.svh"

module tmbpf_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  tmbpf_pkg::qentry_t      push_entry,
    output logic                    full,
    input  wire logic               pop,
    output logic                    head_valid,
    output tmbpf_pkg::qentry_t      head
);

    localparam int DEPTH = tmbpf_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    tmbpf_pkg::qentry_t entries [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full       = count_reg == DEPTH_CNT;
    assign head_valid = count_reg != '0;
    assign head       = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    `TMBPF_ASSERT(a_count_bound, count_reg <= DEPTH_CNT, "queue count exceeds depth")
    `TMBPF_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count missed a push")
    `TMBPF_ASSERT(a_pop_nonempty, pop |-> head_valid, "pop from empty queue")

endmodule

`default_nettype wire

// ===== sv/tmbpf_back.sv =====
// Back end: video RAM and palette, memory writes and the three-read pixel fetch.
`default_nettype none
`include "tile_map_background_pixel_fetch_assert.svh"

module tmbpf_back #(
    parameter int VRAM_HALFWORDS  = tmbpf_pkg::VRAM_HALFWORDS_DEF,
    parameter int PALETTE_ENTRIES = tmbpf_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [1:0]                       tile_block,
    input  wire logic                             head_valid,
    input  tmbpf_pkg::qentry_t                    head,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [tmbpf_pkg::M_DATA_W-1:0]        m_tdata,
    output logic [tmbpf_pkg::M_USER_W-1:0]        m_tuser
);

    localparam int BW = tmbpf_pkg::BYTE_ADDR_W;
    localparam int AW = $clog2(VRAM_HALFWORDS);
    localparam int PW = $clog2(PALETTE_ENTRIES);
    localparam logic [BW-1:0] VRAM_LIMIT = BW'(VRAM_HALFWORDS);

    tmbpf_pkg::back_state_t state_reg;
    tmbpf_pkg::back_state_t state_next;

    logic       inside_reg;
    logic       affine_reg;
    logic       byte_hi_reg;
    logic [2:0] fine_x_reg;
    logic [2:0] fine_y_reg;
    logic [3:0] bank_reg;
    logic [1:0] sel_reg;

    logic        m_valid_reg;
    logic        m_valid_next;
    logic [15:0] m_color_reg;
    logic        m_inside_reg;

    logic          vram_we;
    logic          vram_re;
    logic [AW-1:0] vram_raddr;
    logic [15:0]   vram_rdata;
    logic          pal_we;
    logic          pal_re;
    logic [PW-1:0] pal_raddr;
    logic [15:0]   pal_rdata;
    logic          out_free;
    logic          out_load;

    logic [2:0]    tx;
    logic [2:0]    ty;
    logic [7:0]    tile_byte_num;
    logic [BW-1:0] text_row_byte;
    logic [BW-1:0] aff_pix_byte;
    logic [BW-1:0] tile_byte;
    logic [15:0]   tile_hw;
    logic [1:0]    sel_new;
    logic [3:0]    nib;
    logic [7:0]    pal_idx;

    tmbpf_ram #(
        .WIDTH(16),
        .DEPTH(VRAM_HALFWORDS)
    ) u_vram (
        .aclk (aclk),
        .we   (vram_we),
        .waddr(head.wr_addr[AW-1:0]),
        .wdata(head.wr_data),
        .re   (vram_re),
        .raddr(vram_raddr),
        .rdata(vram_rdata)
    );

    tmbpf_ram #(
        .WIDTH(16),
        .DEPTH(PALETTE_ENTRIES)
    ) u_palette (
        .aclk (aclk),
        .we   (pal_we),
        .waddr(head.wr_addr[PW-1:0]),
        .wdata(head.wr_data),
        .re   (pal_re),
        .raddr(pal_raddr),
        .rdata(pal_rdata)
    );

    // Map entry to tile row or tile pixel address; valid while the map read data is up.
    always_comb begin
        tx            = fine_x_reg ^ {3{vram_rdata[10]}};
        ty            = fine_y_reg ^ {3{vram_rdata[11]}};
        tile_byte_num = byte_hi_reg ? vram_rdata[15:8] : vram_rdata[7:0];
        text_row_byte = BW'({tile_block, 14'b0}) + BW'({vram_rdata[9:0], ty, tx[2], 1'b0});
        aff_pix_byte  = BW'({tile_block, 14'b0}) + BW'({tile_byte_num, fine_y_reg, fine_x_reg});
        tile_byte     = affine_reg ? aff_pix_byte : text_row_byte;
        tile_hw       = tmbpf_pkg::wrap_hw(tile_byte, VRAM_LIMIT);
        sel_new       = affine_reg ? {1'b0, tile_byte[0]} : tx[1:0];
    end

    // Tile data to palette index; valid while the tile read data is up.
    always_comb begin
        case (sel_reg)
            2'd0:    nib = vram_rdata[3:0];
            2'd1:    nib = vram_rdata[7:4];
            2'd2:    nib = vram_rdata[11:8];
            default: nib = vram_rdata[15:12];
        endcase
        if (affine_reg) begin
            pal_idx = sel_reg[0] ? vram_rdata[15:8] : vram_rdata[7:0];
        end else begin
            pal_idx = {bank_reg, nib};
        end
        pal_raddr = PW'(pal_idx);
    end

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tmbpf_pkg::BK_IDLE: begin
                if (head_valid && head.kind == tmbpf_pkg::CMD_PIXEL) begin
                    state_next = tmbpf_pkg::BK_MAP;
                end
            end
            tmbpf_pkg::BK_MAP:  state_next = tmbpf_pkg::BK_TILE;
            tmbpf_pkg::BK_TILE: state_next = tmbpf_pkg::BK_PAL;
            tmbpf_pkg::BK_PAL: begin
                if (out_free) begin
                    state_next = tmbpf_pkg::BK_IDLE;
                end
            end
            default: state_next = tmbpf_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        pop        = 1'b0;
        vram_we    = 1'b0;
        vram_re    = 1'b0;
        vram_raddr = head.map_hw[AW-1:0];
        pal_we     = 1'b0;
        pal_re     = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            tmbpf_pkg::BK_IDLE: begin
                pop     = head_valid;
                vram_we = head_valid && head.kind == tmbpf_pkg::CMD_VRAM_WR;
                pal_we  = head_valid && head.kind == tmbpf_pkg::CMD_PAL_WR;
                vram_re = head_valid && head.kind == tmbpf_pkg::CMD_PIXEL && head.in_map;
            end
            tmbpf_pkg::BK_MAP: begin
                vram_re    = inside_reg;
                vram_raddr = tile_hw[AW-1:0];
            end
            tmbpf_pkg::BK_TILE: begin
                pal_re = inside_reg;
            end
            tmbpf_pkg::BK_PAL: begin
                out_load = out_free;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tmbpf_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            inside_reg  <= head.in_map;
            affine_reg  <= head.affine;
            byte_hi_reg <= head.byte_hi;
            fine_x_reg  <= head.fine_x;
            fine_y_reg  <= head.fine_y;
        end
        if (state_reg == tmbpf_pkg::BK_MAP) begin
            bank_reg <= vram_rdata[15:12];
            sel_reg  <= sel_new;
        end
        if (out_load) begin
            m_color_reg  <= inside_reg ? pal_rdata : 16'h0000;
            m_inside_reg <= inside_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_color_reg;
    assign m_tuser  = m_inside_reg;

    `TMBPF_ASSERT_NEXT(a_map_then_tile, state_reg == tmbpf_pkg::BK_MAP, state_reg == tmbpf_pkg::BK_TILE, "map fetch not followed by tile fetch")
    `TMBPF_ASSERT(a_outside_black, m_valid_reg && !m_inside_reg |-> m_color_reg == 16'h0000, "outside pixel with nonzero color")
    `TMBPF_ASSERT_NEXT(a_load_shows, out_load, m_valid_reg, "loaded result not presented")

endmodule

`default_nettype wire
